// ===== design/mwm_pkg.sv =====
package mwm_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES = 24;

	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int SPW = 18;
	localparam int AW = 17;
	localparam int QW = 16;
	localparam int RW = 34;
	localparam int DW = 18;

	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam logic [15:0] PHASE_OFS = 16'h2000;
	localparam logic [45:0] GAIN_Q30 = 46'd652032874;
	localparam logic signed [31:0] QUARTER_TURN = 32'sh4000_0000;
	localparam logic signed [ZW-1:0] HALF_TURN = 33'sh0_8000_0000;
	localparam logic signed [XW-1:0] ROUND_Q15 = 34'sd16384;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [15:0]   rot;
	} cordic_t;

	typedef struct packed {
		logic signed [SPW-1:0] sp;
		logic [QW-1:0]         quo;
		logic [RW-1:0]         rem;
	} lane_t;

	typedef struct packed {
		lane_t [3:0]   lane;
		logic [DW-1:0] dvs;
		logic          norm;
	} div_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] a;
		case (i)
			0: a = 32'd536870912;
			1: a = 32'd316933406;
			2: a = 32'd167458907;
			3: a = 32'd85004756;
			4: a = 32'd42667331;
			5: a = 32'd21354465;
			6: a = 32'd10679838;
			7: a = 32'd5340245;
			8: a = 32'd2670163;
			9: a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== design/mwm_cmd_if.sv =====
interface mwm_cmd_if;
	logic               valid;
	logic               ready;
	logic [15:0]        magnitude;
	logic [15:0]        angle;
	logic signed [15:0] rotation;

	modport source (output valid, magnitude, angle, rotation, input ready);
	modport sink (input valid, magnitude, angle, rotation, output ready);
endinterface

// ===== design/mwm_spd_if.sv =====
interface mwm_spd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_front_left;
	logic signed [15:0] speed_front_right;
	logic signed [15:0] speed_back_right;
	logic signed [15:0] speed_back_left;
	logic               normalized;

	modport source (output valid, speed_front_left, speed_front_right, speed_back_right,
		speed_back_left, normalized, input ready);
	modport sink (input valid, speed_front_left, speed_front_right, speed_back_right,
		speed_back_left, normalized, output ready);
endinterface

// ===== design/mecanum_wheel_mixer_core.sv =====
// channel   dir   payload
// cmd       in    magnitude, angle, rotation
// spd       out   four wheel speeds, normalized
//
// one request enters per cycle while the output is not stalled; each passes these register
// stages: 2 setup, one per cordic stage (at most ATAN_ENTRIES), 3 mix, 16 divider bit stages, 1 output
// reset clears only valid bits; no state is kept between requests
// a stalled output freezes the whole pipeline in place, cmd.ready drops with it
module mecanum_wheel_mixer_core #(
	parameter int CORDIC_STAGES = mwm_pkg::CORDIC_STAGES_DEF
) (
	input logic  clk,
	input logic  arst_n,
	mwm_cmd_if.sink   cmd,
	mwm_spd_if.source spd
);
	import mwm_pkg::*;

	localparam int NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	logic    en;
	logic    c_valid [NS+1];
	cordic_t c_data [NS+1];
	logic    d_valid [QW+1];
	div_t    d_data [QW+1];

	logic                  out_valid_q;
	logic signed [15:0]    speed_q [4];
	logic                  norm_q;
	logic signed [15:0]    fin [4];
	logic signed [SPW-1:0] qs, v;

	assign en = !out_valid_q || spd.ready;
	assign cmd.ready = en;

	mwm_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cmd.valid),
		.magnitude (cmd.magnitude),
		.angle     (cmd.angle),
		.rotation  (cmd.rotation),
		.out_valid (c_valid[0]),
		.out_data  (c_data[0])
	);

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		mwm_cordic_stage #(.IDX(i)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (c_valid[i]),
			.in_data   (c_data[i]),
			.out_valid (c_valid[i+1]),
			.out_data  (c_data[i+1])
		);
	end

	mwm_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c_valid[NS]),
		.in_data   (c_data[NS]),
		.out_valid (d_valid[0]),
		.out_data  (d_data[0])
	);

	for (genvar b = 0; b < QW; b++) begin : g_div
		mwm_div_stage #(.BIT(QW-1-b)) u_bit (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (d_valid[b]),
			.in_data   (d_data[b]),
			.out_valid (d_valid[b+1]),
			.out_data  (d_data[b+1])
		);
	end

	always_comb begin
		qs = '0;
		v = '0;
		for (int k = 0; k < 4; k++) begin
			qs = SPW'(d_data[QW].lane[k].quo);
			if (!d_data[QW].norm)
				v = d_data[QW].lane[k].sp;
			else if (d_data[QW].lane[k].sp[SPW-1])
				v = -qs;
			else
				v = qs;
			if (v > 18'sd32767)
				fin[k] = 16'sh7fff;
			else if (v < -18'sd32768)
				fin[k] = 16'sh8000;
			else
				fin[k] = v[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= d_valid[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				speed_q[k] <= fin[k];
			norm_q <= d_data[QW].norm;
		end
	end

	assign spd.valid = out_valid_q;
	assign spd.speed_front_left = speed_q[0];
	assign spd.speed_front_right = speed_q[1];
	assign spd.speed_back_right = speed_q[2];
	assign spd.speed_back_left = speed_q[3];
	assign spd.normalized = norm_q;

	// phase reduced to within a quarter turn before the first rotation
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid[0] |-> (c_data[0].z <= 33'sh0_4000_0000) && (c_data[0].z >= -33'sh0_4000_0000))
		else $error("cordic phase out of range");

	// the quotient of a normalized request never exceeds full scale
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_valid[QW] && d_data[QW].norm |->
			(d_data[QW].lane[0].quo <= ONE_Q15) && (d_data[QW].lane[1].quo <= ONE_Q15) &&
			(d_data[QW].lane[2].quo <= ONE_Q15) && (d_data[QW].lane[3].quo <= ONE_Q15))
		else $error("divider quotient above full scale");

	// after scaling the largest wheel sits at full scale
	a_norm_full: assert property (@(posedge clk) disable iff (!arst_n)
		spd.valid && spd.normalized |->
			(speed_q[0] == 16'sh7fff) || (speed_q[0] == 16'sh8000) ||
			(speed_q[1] == 16'sh7fff) || (speed_q[1] == 16'sh8000) ||
			(speed_q[2] == 16'sh7fff) || (speed_q[2] == 16'sh8000) ||
			(speed_q[3] == 16'sh7fff) || (speed_q[3] == 16'sh8000))
		else $error("normalized request without full-scale wheel");
endmodule

// ===== design/mwm_prep.sv =====
module mwm_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        magnitude,
	input  logic [15:0]        angle,
	input  logic signed [15:0] rotation,
	output logic               out_valid,
	output mwm_pkg::cordic_t   out_data
);
	import mwm_pkg::*;

	logic [15:0]          mag_sat;
	logic [15:0]          ph;
	logic signed [31:0]   z_raw;
	logic signed [ZW-1:0] z_ext;
	logic signed [ZW-1:0] z_red;
	logic                 flip;
	logic [45:0]          prod;

	logic                 valid_s1;
	logic [30:0]          x0_s1;
	logic                 flip_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [15:0]   rot_s1;
	logic                 valid_s2;
	cordic_t              data_s2;
	logic signed [XW-1:0] x0_ext;

	assign mag_sat = (magnitude > ONE_Q15) ? ONE_Q15 : magnitude;
	assign ph = angle + PHASE_OFS;
	assign z_raw = signed'({ph, 16'h0000});
	assign z_ext = ZW'(z_raw);
	assign flip = (z_raw > QUARTER_TURN) || (z_raw < -QUARTER_TURN);
	assign prod = 46'(mag_sat) * GAIN_Q30;

	always_comb begin
		if (!flip)
			z_red = z_ext;
		else if (z_raw[31])
			z_red = z_ext + HALF_TURN;
		else
			z_red = z_ext - HALF_TURN;
	end

	assign x0_ext = signed'(XW'(x0_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1 <= prod[45:15];
			flip_s1 <= flip;
			z_s1 <= z_red;
			rot_s1 <= rotation;
			data_s2.x <= flip_s1 ? -x0_ext : x0_ext;
			data_s2.y <= '0;
			data_s2.z <= z_s1;
			data_s2.rot <= rot_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;
endmodule

// ===== design/mwm_cordic_stage.sv =====
module mwm_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  mwm_pkg::cordic_t in_data,
	output logic             out_valid,
	output mwm_pkg::cordic_t out_data
);
	import mwm_pkg::*;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [ZW-1:0] ang;
	cordic_t              nxt;
	logic                 valid_s1;
	cordic_t              data_s1;

	assign dx = in_data.y >>> IDX;
	assign dy = in_data.x >>> IDX;
	assign ang = signed'(ZW'(atan_turn(IDX)));

	always_comb begin
		nxt.rot = in_data.rot;
		if (!in_data.z[ZW-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - ang;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;
endmodule

// ===== design/mwm_mix.sv =====
module mwm_mix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  mwm_pkg::cordic_t in_data,
	output logic             out_valid,
	output mwm_pkg::div_t    out_data
);
	import mwm_pkg::*;

	function automatic logic signed [16:0] to_q15(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] sh;
		logic signed [16:0]   r;
		sh = (v + ROUND_Q15) >>> 15;
		if (sh > 34'sd32768)
			r = 17'sd32768;
		else if (sh < -34'sd32768)
			r = -17'sd32768;
		else
			r = sh[16:0];
		return r;
	endfunction

	logic                  valid_s1, valid_s2, valid_s3;
	logic signed [16:0]    cos_s1, sin_s1;
	logic signed [15:0]    rot_s1;
	logic signed [SPW-1:0] sp [4];
	logic [AW-1:0]         ab [4];
	logic signed [SPW-1:0] sp_s2 [4];
	logic [AW-1:0]         ab_s2 [4];
	logic signed [SPW-1:0] c_e, s_e, r_e;
	logic [AW-1:0]         m01, m23, big;
	div_t                  data_s3;

	assign c_e = SPW'(cos_s1);
	assign s_e = SPW'(sin_s1);
	assign r_e = SPW'(rot_s1);

	always_comb begin
		sp[0] = -(s_e + r_e);
		sp[1] = c_e - r_e;
		sp[2] = -(c_e + r_e);
		sp[3] = s_e - r_e;
		for (int k = 0; k < 4; k++)
			ab[k] = sp[k][SPW-1] ? AW'(-sp[k]) : AW'(sp[k]);
	end

	assign m01 = (ab_s2[1] > ab_s2[0]) ? ab_s2[1] : ab_s2[0];
	assign m23 = (ab_s2[3] > ab_s2[2]) ? ab_s2[3] : ab_s2[2];
	assign big = (m23 > m01) ? m23 : m01;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1 <= to_q15(in_data.x);
			sin_s1 <= to_q15(in_data.y);
			rot_s1 <= in_data.rot;
			for (int k = 0; k < 4; k++) begin
				sp_s2[k] <= sp[k];
				ab_s2[k] <= ab[k];
				data_s3.lane[k].sp <= sp_s2[k];
				data_s3.lane[k].quo <= '0;
				data_s3.lane[k].rem <= {1'b0, ab_s2[k], 16'h0000} + RW'(big);
			end
			data_s3.dvs <= {big, 1'b0};
			data_s3.norm <= big > AW'(ONE_Q15);
		end
	end

	assign out_valid = valid_s3;
	assign out_data = data_s3;
endmodule

// ===== design/mwm_div_stage.sv =====
module mwm_div_stage #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  mwm_pkg::div_t in_data,
	output logic          out_valid,
	output mwm_pkg::div_t out_data
);
	import mwm_pkg::*;

	logic [RW-1:0] sub;
	div_t          nxt;
	logic          valid_s1;
	div_t          data_s1;

	assign sub = RW'(in_data.dvs) << BIT;

	always_comb begin
		nxt = in_data;
		for (int k = 0; k < 4; k++) begin
			if (in_data.lane[k].rem >= sub) begin
				nxt.lane[k].rem = in_data.lane[k].rem - sub;
				nxt.lane[k].quo[BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;
endmodule
